### sv/tpa_pkg.sv
// Package for the triangle perimeter/area unit: widths and small types.
// No dependencies.
package tpa_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 16;
    localparam int unsigned LEN_FRAC_DEF    = 8;
    localparam int unsigned PERIM_WIDTH     = 27;
    localparam int unsigned AREA_WIDTH      = 32;

endpackage

### sv/tpa_sqrt_cell.sv
// One restoring square-root step: decides one result bit per cycle stage.
// Depends on tpa_pkg.
module tpa_sqrt_cell #(
    parameter int unsigned RAD_WIDTH = 50,
    parameter int unsigned ROOT_WIDTH = 25,
    parameter int unsigned STEP = 0
) (
    input  logic                  clk,
    input  logic [RAD_WIDTH-1:0]  rem_in,
    input  logic [ROOT_WIDTH-1:0] root_in,
    output logic [RAD_WIDTH-1:0]  rem_out,
    output logic [ROOT_WIDTH-1:0] root_out
);
    import tpa_pkg::*;

    localparam int unsigned BITPOS = ROOT_WIDTH - 1 - STEP;

    logic [RAD_WIDTH+1:0]  trial;
    logic [RAD_WIDTH+1:0]  rem_wide;
    logic [RAD_WIDTH-1:0]  rem_next;
    logic [ROOT_WIDTH-1:0] root_next;
    logic [RAD_WIDTH-1:0]  rem_reg;
    logic [ROOT_WIDTH-1:0] root_reg;

    // trial = (2*root + bit) * bit, bit = 2^BITPOS
    always_comb
    begin
        trial    = ((RAD_WIDTH+2)'(root_in) << (BITPOS + 1))
                 + ((RAD_WIDTH+2)'(1) << (2 * BITPOS));
        rem_wide = (RAD_WIDTH+2)'(rem_in);
        if (rem_wide >= trial)
        begin
            rem_next  = RAD_WIDTH'(rem_wide - trial);
            root_next = root_in | (ROOT_WIDTH'(1) << BITPOS);
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

### sv/tpa_sqrt_chain.sv
// Chain of sqrt cells: one root bit per stage, a new radicand every cycle.
// Depends on tpa_pkg and tpa_sqrt_cell.
module tpa_sqrt_chain #(
    parameter int unsigned RAD_WIDTH = 50,
    parameter int unsigned ROOT_WIDTH = 25
) (
    input  logic                  clk,
    input  logic [RAD_WIDTH-1:0]  radicand,
    output logic [ROOT_WIDTH-1:0] root
);
    import tpa_pkg::*;

    logic [RAD_WIDTH-1:0]  rem_tap  [ROOT_WIDTH+1];
    logic [ROOT_WIDTH-1:0] root_tap [ROOT_WIDTH+1];

    assign rem_tap[0]  = radicand;
    assign root_tap[0] = '0;

    for (genvar i = 0; i < ROOT_WIDTH; i++)
    begin : g_cell
        tpa_sqrt_cell #(
            .RAD_WIDTH (RAD_WIDTH),
            .ROOT_WIDTH(ROOT_WIDTH),
            .STEP      (i)
        ) u_cell (
            .clk     (clk),
            .rem_in  (rem_tap[i]),
            .root_in (root_tap[i]),
            .rem_out (rem_tap[i+1]),
            .root_out(root_tap[i+1])
        );
    end

    assign root = root_tap[ROOT_WIDTH];
endmodule

### sv/triangle_perimeter_area_unit.sv
// Top level of the triangle perimeter / doubled area / equilateral unit.
// Depends on tpa_pkg, tpa_sqrt_chain.
//
// Channel | Dir | Handshake          | Payload
// --------+-----+--------------------+--------------------------------------
// in      | in  | start & !busy      | first/second/third _x,_y (signed)
// out     | out | done (one cycle)   | perimeter, doubled_area, equilateral
//
// One triangle per clock; busy is always low. done rises after three front
// stages, one root bit per sqrt cell (W+F+1 cells, W = COORD_WIDTH,
// F = LENGTH_FRAC_BITS), then the output register. Stages: deltas,
// squares/products, sums, the sqrt cell chain, then perimeter add. Reset
// clears only the valid pipe; the receiver cannot stall, so no backpressure
// exists.
module triangle_perimeter_area_unit #(
    parameter int unsigned COORD_WIDTH      = tpa_pkg::COORD_WIDTH_DEF,
    parameter int unsigned LENGTH_FRAC_BITS = tpa_pkg::LEN_FRAC_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [COORD_WIDTH-1:0]        first_x,
    input  logic signed [COORD_WIDTH-1:0]        first_y,
    input  logic signed [COORD_WIDTH-1:0]        second_x,
    input  logic signed [COORD_WIDTH-1:0]        second_y,
    input  logic signed [COORD_WIDTH-1:0]        third_x,
    input  logic signed [COORD_WIDTH-1:0]        third_y,
    output logic                                 done,
    output logic [tpa_pkg::PERIM_WIDTH-1:0]      perimeter,
    output logic [tpa_pkg::AREA_WIDTH-1:0]       doubled_area,
    output logic                                 equilateral
);
    import tpa_pkg::*;

    localparam int unsigned DW   = COORD_WIDTH + 1;          // delta width
    localparam int unsigned MW   = 2 * DW;                   // product width
    localparam int unsigned SW   = 2 * COORD_WIDTH + 1;      // squared distance
    localparam int unsigned RW   = SW + 2 * LENGTH_FRAC_BITS + 1; // even radicand
    localparam int unsigned QW   = RW / 2;                   // root width
    localparam int unsigned PW   = QW + 2;                   // perimeter sum
    localparam int unsigned CW   = MW + 1;                   // cross width
    localparam int unsigned LAT  = QW + 4;                   // valid pipe
    localparam int unsigned FLAT = QW;                       // side-data delay

    // stage 1: deltas
    logic signed [DW-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, dxc_reg, dyc_reg;
    // stage 2: squares and cross terms
    logic [MW-1:0]        sxa_reg, sya_reg, sxb_reg, syb_reg, sxc_reg, syc_reg;
    logic signed [MW-1:0] p1_reg, p2_reg;
    // stage 3: squared distances, abs cross, flag
    logic [SW-1:0]        da_reg, db_reg, dc_reg;
    logic [CW-1:0]        area_reg;
    logic                 eq_reg;
    logic signed [CW-1:0] cross_sum;
    logic [CW-1:0]        area_abs;
    logic [SW-1:0]        da_next, db_next, dc_next;
    // side lengths
    logic [QW-1:0]        la, lb, lc;
    logic [PW-1:0]        psum;
    logic [PERIM_WIDTH-1:0] perim_reg;
    logic [AREA_WIDTH-1:0]  area_out_reg;
    logic                   eq_out_reg;
    logic [CW-1:0]        area_dly [FLAT];
    logic                 eq_dly   [FLAT];
    logic [LAT-1:0]       vld_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk)
    begin
        dxa_reg <= DW'(second_x) - DW'(first_x);
        dya_reg <= DW'(second_y) - DW'(first_y);
        dxb_reg <= DW'(third_x)  - DW'(second_x);
        dyb_reg <= DW'(third_y)  - DW'(second_y);
        dxc_reg <= DW'(first_x)  - DW'(third_x);
        dyc_reg <= DW'(first_y)  - DW'(third_y);
    end

    // edges b-a and c-a are (dxa,dya) and (-dxc,-dyc)
    always_ff @(posedge clk)
    begin
        sxa_reg <= MW'(dxa_reg * dxa_reg);
        sya_reg <= MW'(dya_reg * dya_reg);
        sxb_reg <= MW'(dxb_reg * dxb_reg);
        syb_reg <= MW'(dyb_reg * dyb_reg);
        sxc_reg <= MW'(dxc_reg * dxc_reg);
        syc_reg <= MW'(dyc_reg * dyc_reg);
        p1_reg  <= MW'(dya_reg * dxc_reg);  // -(y2-y1)*(x3-x1) sign-flipped below
        p2_reg  <= MW'(dxa_reg * dyc_reg);
    end

    always_comb
    begin
        // cross = dxa*(-dyc) - dya*(-dxc) = p1 - p2
        cross_sum = CW'(p1_reg) - CW'(p2_reg);
        area_abs  = cross_sum[CW-1] ? CW'(-cross_sum) : CW'(cross_sum);
        da_next   = SW'(sxa_reg) + SW'(sya_reg);
        db_next   = SW'(sxb_reg) + SW'(syb_reg);
        dc_next   = SW'(sxc_reg) + SW'(syc_reg);
    end

    always_ff @(posedge clk)
    begin
        da_reg   <= da_next;
        db_reg   <= db_next;
        dc_reg   <= dc_next;
        area_reg <= area_abs;
        eq_reg   <= (da_next == db_next) && (db_next == dc_next);
    end

    tpa_sqrt_chain #(.RAD_WIDTH(RW), .ROOT_WIDTH(QW)) u_sqrt_a (
        .clk(clk), .radicand(RW'(da_reg) << (2 * LENGTH_FRAC_BITS)), .root(la));
    tpa_sqrt_chain #(.RAD_WIDTH(RW), .ROOT_WIDTH(QW)) u_sqrt_b (
        .clk(clk), .radicand(RW'(db_reg) << (2 * LENGTH_FRAC_BITS)), .root(lb));
    tpa_sqrt_chain #(.RAD_WIDTH(RW), .ROOT_WIDTH(QW)) u_sqrt_c (
        .clk(clk), .radicand(RW'(dc_reg) << (2 * LENGTH_FRAC_BITS)), .root(lc));

    // area and flag ride alongside the sqrt chain
    always_ff @(posedge clk)
    begin
        area_dly[0] <= area_reg;
        eq_dly[0]   <= eq_reg;
        for (int i = 1; i < FLAT; i++)
        begin
            area_dly[i] <= area_dly[i-1];
            eq_dly[i]   <= eq_dly[i-1];
        end
    end

    assign psum = PW'(la) + PW'(lb) + PW'(lc);

    // saturating output register
    always_ff @(posedge clk)
    begin
        if (PW > PERIM_WIDTH && (psum >> PERIM_WIDTH) != '0)
            perim_reg <= '1;
        else
            perim_reg <= PERIM_WIDTH'(psum);
        if (CW > AREA_WIDTH && (area_dly[FLAT-1] >> AREA_WIDTH) != '0)
            area_out_reg <= '1;
        else
            area_out_reg <= AREA_WIDTH'(area_dly[FLAT-1]);
        eq_out_reg <= eq_dly[FLAT-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    assign done         = vld_reg[LAT-1];
    assign perimeter    = perim_reg;
    assign doubled_area = area_out_reg;
    assign equilateral  = eq_out_reg;
endmodule
